// File: sv/mlp_pkg.sv
package mlp_pkg;

	localparam int MAX_INPUTS_DEF  = 16;
	localparam int MAX_HIDDEN_DEF  = 16;
	localparam int MAX_LAYERS_DEF  = 4;
	localparam int MAX_OUTPUTS_DEF = 8;
	localparam int RESULT_LIMIT    = 8;
	localparam int TBL_DEPTH       = 256;
	localparam int TBL_AW          = $clog2(TBL_DEPTH);
	localparam int IDX_W           = 6;
	localparam int CNT_W           = 8;
	localparam int OUT_LAYER_SEL   = 4;

	typedef enum logic [1:0] {
		REQ_WEIGHT  = 2'd0,
		REQ_FEATURE = 2'd1,
		REQ_TARGET  = 2'd2,
		REQ_NONE    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		CFG_INPUTS  = 2'd0,
		CFG_HIDDEN  = 2'd1,
		CFG_LAYERS  = 2'd2,
		CFG_OUTPUTS = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_OUTWAIT
	} state_t;

	typedef struct packed {
		logic             vld;
		logic             first;
		logic             last;
		logic             outl;
		logic             lastn;
		logic             bank;
		logic [IDX_W-1:0] idx;
	} mac_ctl_t;

	typedef logic [12:0] sig_tbl_t [TBL_DEPTH];

	function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
		longint unsigned q;
		longint unsigned r;
		q = 64'd0;
		r = 64'd0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic longint unsigned exp_neg_frac(longint unsigned f);
		longint unsigned pos;
		longint unsigned neg;
		longint unsigned term;
		pos  = 64'd1 << 30;
		neg  = 64'd0;
		term = 64'd1 << 30;
		for (int k = 1; k <= 24; k++) begin
			term = udiv64(term * f, 64'd4096 * longint'(k));
			if (k[0]) begin
				neg = neg + term;
			end else begin
				pos = pos + term;
			end
		end
		return pos - neg;
	endfunction

	function automatic sig_tbl_t build_sig_tbl();
		sig_tbl_t        t;
		longint unsigned e1;
		longint          c;
		longint unsigned a;
		longint unsigned n;
		longint unsigned e;
		longint unsigned den;
		longint unsigned s;
		e1 = exp_neg_frac(64'd4096);
		for (int i = 0; i < TBL_DEPTH; i++) begin
			c = longint'(((2 * longint'(i) + 1) * 65536) >>> (TBL_AW + 1)) - 32768;
			a = (c < 0) ? longint'(-c) : longint'(c);
			n = a >> 12;
			e = exp_neg_frac(a & 64'd4095);
			for (int j = 0; j < 8; j++) begin
				if (longint'(j) < longint'(n)) begin
					e = (e * e1) >> 30;
				end
			end
			den = (64'd1 << 30) + e;
			s = udiv64((64'd4096 << 30) + (den >> 1), den);
			t[i] = (c < 0) ? 13'(64'd4096 - s) : 13'(s);
		end
		return t;
	endfunction

endpackage

// File: sv/mlp_forward_inference_core.sv
// Forward-pass engine for a small fully connected sigmoid network, Q4.12.
// Input stream s_axis: tuser = req_type, tdata = layer/neuron/source/value.
//   weight and feature writes give no result.
//   a target beat runs the whole network and gives one beat per output neuron
//   on m_axis (tdata = neuron, activation, error; tlast on the last one).
// Config port: cfg_we, cfg_addr, cfg_data; write only while idle.
// A run streams every multiply-accumulate through the single shared MAC and
// drains the MAC pipeline after each hidden layer and after each output neuron.
// s_tready stays low for the whole run and until the last result beat is
// taken; one item is worked on at a time.
// After reset the weight store is zeroed by a pass of one entry per cycle
// over all (MAX_LAYERS*MAX_HIDDEN+MAX_OUTPUTS)*max(MAX_INPUTS,MAX_HIDDEN) entries,
// 1152 by default, with s_tready low; unwritten features read as zero at once.
// A stalled m_axis holds its beat; the next output neuron is computed only
// after the held beat is taken, so no result is lost.
module mlp_forward_inference_core
	import mlp_pkg::*;
#(
	parameter int MAX_INPUTS  = MAX_INPUTS_DEF,
	parameter int MAX_HIDDEN  = MAX_HIDDEN_DEF,
	parameter int MAX_LAYERS  = MAX_LAYERS_DEF,
	parameter int MAX_OUTPUTS = MAX_OUTPUTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // layer_sel[2:0] neuron_sel[6:3] source_sel[10:7] data_value[26:11]
	input  logic [1:0]  s_tuser,  // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // out_neuron[2:0] out_activation[15:3] out_error[31:16]
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [4:0]  cfg_data
);

	localparam int WSRC   = (MAX_INPUTS > MAX_HIDDEN) ? MAX_INPUTS : MAX_HIDDEN;
	localparam int WDEPTH = (MAX_LAYERS * MAX_HIDDEN + MAX_OUTPUTS) * WSRC;
	localparam int WAW    = $clog2(WDEPTH);
	localparam int SW     = (WSRC > 1) ? $clog2(WSRC) : 1;
	localparam int FAW    = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
	localparam int AAW    = $clog2(2 * MAX_HIDDEN);
	localparam int LW     = $clog2(MAX_LAYERS + 1);
	localparam int NMAX   = (MAX_HIDDEN > MAX_OUTPUTS) ? MAX_HIDDEN : MAX_OUTPUTS;
	localparam int NW     = (NMAX > 1) ? $clog2(NMAX) : 1;
	localparam int OMAX   = (MAX_OUTPUTS < RESULT_LIMIT) ? MAX_OUTPUTS : RESULT_LIMIT;

	logic [2:0]         in_layer;
	logic [3:0]         in_neuron;
	logic [3:0]         in_source;
	logic signed [15:0] in_value;
	req_t               in_req;
	logic               s_acc;

	logic [4:0] ai_q, ah_q;
	logic [2:0] al_q;
	logic [3:0] ao_q;
	logic [CNT_W-1:0] ni, nh, nl, no;

	state_t state_q, state_d;
	logic [WAW-1:0] clr_q;
	logic [LW-1:0]  l_q;
	logic [NW-1:0]  n_q;
	logic [SW-1:0]  s_q;
	logic [2:0]     dcnt_q;
	logic signed [15:0] tgt_q;

	logic signed [15:0] wmem [WDEPTH];
	logic signed [15:0] fmem [MAX_INPUTS];
	logic [MAX_INPUTS-1:0] fvld_q;
	logic signed [15:0] amem [2 * MAX_HIDDEN];

	logic              outl, lay0, src_last, neur_last;
	logic [CNT_W-1:0]  nsrc;
	logic              rd_bank;
	logic [WAW-1:0]    rd_waddr;
	logic [AAW-1:0]    rd_aaddr;
	logic              w_hid_ok, w_out_ok;
	logic [LW-1:0]     w_l;
	logic [WAW-1:0]    wr_waddr;
	logic              issue;
	mac_ctl_t          ctl_s1, ctl_issue, ctl_done;
	logic              lay0_s1, fok_s1;
	logic signed [15:0] w_s1, f_s1, a_s1, x_s1;
	logic [12:0]       act_done;

	logic [2:0]         on_q;
	logic [12:0]        oact_q;
	logic signed [15:0] oerr_q;
	logic               olast_q, ovld_q;
	logic signed [17:0] diff;

	assign in_layer  = s_tdata[2:0];
	assign in_neuron = s_tdata[6:3];
	assign in_source = s_tdata[10:7];
	assign in_value  = s_tdata[26:11];
	assign in_req    = req_t'(s_tuser);
	assign s_tready  = (state_q == ST_IDLE) && !ovld_q;
	assign s_acc     = s_tvalid & s_tready;

	function automatic logic [CNT_W-1:0] clampc(logic [CNT_W-1:0] v, int hi);
		if (v == '0) begin
			return CNT_W'(1);
		end else if (int'(v) > hi) begin
			return CNT_W'(hi);
		end else begin
			return v;
		end
	endfunction

	assign ni = clampc(CNT_W'(ai_q), MAX_INPUTS);
	assign nh = clampc(CNT_W'(ah_q), MAX_HIDDEN);
	assign nl = clampc(CNT_W'(al_q), MAX_LAYERS);
	assign no = clampc(CNT_W'(ao_q), OMAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ai_q <= 5'd2;
			ah_q <= 5'd2;
			al_q <= 3'd2;
			ao_q <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_addr))
				CFG_INPUTS:  ai_q <= cfg_data;
				CFG_HIDDEN:  ah_q <= cfg_data;
				CFG_LAYERS:  al_q <= cfg_data[2:0];
				CFG_OUTPUTS: ao_q <= cfg_data[3:0];
				default:     ai_q <= ai_q;
			endcase
		end
	end

	assign outl      = (int'(l_q) == MAX_LAYERS);
	assign lay0      = (l_q == '0);
	assign nsrc      = lay0 ? ni : nh;
	assign src_last  = (CNT_W'(s_q) == nsrc - CNT_W'(1));
	assign neur_last = outl ? (CNT_W'(n_q) == no - CNT_W'(1))
	                        : (CNT_W'(n_q) == nh - CNT_W'(1));
	assign rd_bank   = outl ? ~nl[0] : ~l_q[0];
	assign rd_waddr  = WAW'((WAW'(l_q) * WAW'(MAX_HIDDEN) + WAW'(n_q)) * WAW'(WSRC)
	                   + WAW'(s_q));
	assign rd_aaddr  = AAW'(AAW'(rd_bank) * AAW'(MAX_HIDDEN) + AAW'(s_q));

	assign w_hid_ok = (int'(in_layer) < MAX_LAYERS) && (int'(in_neuron) < MAX_HIDDEN) &&
	                  (int'(in_source) < ((in_layer == 3'd0) ? MAX_INPUTS : MAX_HIDDEN));
	assign w_out_ok = (int'(in_layer) == OUT_LAYER_SEL) &&
	                  (int'(in_neuron) < MAX_OUTPUTS) && (int'(in_source) < MAX_HIDDEN);
	assign w_l      = w_hid_ok ? LW'(in_layer) : LW'(MAX_LAYERS);
	assign wr_waddr = WAW'((WAW'(w_l) * WAW'(MAX_HIDDEN) + WAW'(in_neuron)) * WAW'(WSRC)
	                  + WAW'(in_source));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (int'(clr_q) == WDEPTH - 1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_acc && in_req == REQ_TARGET) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (src_last && (outl || neur_last)) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (dcnt_q == '0) begin
					if (outl) begin
						state_d = neur_last ? ST_IDLE : ST_OUTWAIT;
					end else if (CNT_W'(l_q) + CNT_W'(1) == nl) begin
						state_d = ST_OUTWAIT;
					end else begin
						state_d = ST_RUN;
					end
				end
			end
			ST_OUTWAIT: begin
				if (!ovld_q) state_d = ST_RUN;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		issue = (state_q == ST_RUN);
		ctl_issue.vld   = issue;
		ctl_issue.first = (s_q == '0);
		ctl_issue.last  = src_last;
		ctl_issue.outl  = outl;
		ctl_issue.lastn = neur_last;
		ctl_issue.bank  = l_q[0];
		ctl_issue.idx   = IDX_W'(n_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			l_q     <= '0;
			n_q     <= '0;
			s_q     <= '0;
			dcnt_q  <= '0;
			fvld_q  <= '0;
			ctl_s1  <= '0;
			lay0_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			ctl_s1  <= ctl_issue;
			lay0_s1 <= lay0;
			if (state_q == ST_CLEAR) clr_q <= clr_q + WAW'(1);
			if (s_acc && in_req == REQ_FEATURE && int'(in_source) < MAX_INPUTS) begin
				fvld_q[FAW'(in_source)] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					l_q <= '0;
					n_q <= '0;
					s_q <= '0;
				end
				ST_RUN: begin
					if (src_last) begin
						s_q <= '0;
						if (outl || neur_last) begin
							dcnt_q <= 3'd4;
						end else begin
							n_q <= n_q + NW'(1);
						end
					end else begin
						s_q <= s_q + SW'(1);
					end
				end
				ST_DRAIN: begin
					dcnt_q <= dcnt_q - 3'd1;
					if (dcnt_q == '0) begin
						if (outl) begin
							n_q <= n_q + NW'(1);
						end else begin
							n_q <= '0;
							if (CNT_W'(l_q) + CNT_W'(1) == nl) begin
								l_q <= LW'(MAX_LAYERS);
							end else begin
								l_q <= l_q + LW'(1);
							end
						end
					end
				end
				default: s_q <= s_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			wmem[clr_q] <= '0;
		end else if (s_acc && in_req == REQ_WEIGHT && (w_hid_ok || w_out_ok)) begin
			wmem[wr_waddr] <= in_value;
		end
		if (s_acc && in_req == REQ_FEATURE && int'(in_source) < MAX_INPUTS) begin
			fmem[FAW'(in_source)] <= in_value;
		end
		if (s_acc && in_req == REQ_TARGET) tgt_q <= in_value;
		if (ctl_done.vld && !ctl_done.outl) begin
			amem[AAW'(AAW'(ctl_done.bank) * AAW'(MAX_HIDDEN) + AAW'(ctl_done.idx))] <=
				16'(act_done);
		end
		w_s1   <= wmem[rd_waddr];
		f_s1   <= fmem[FAW'(s_q)];
		fok_s1 <= fvld_q[FAW'(s_q)];
		a_s1   <= amem[rd_aaddr];
	end

	assign x_s1 = lay0_s1 ? (fok_s1 ? f_s1 : '0) : a_s1;

	mlp_fwd_mac #(
		.WSRC(WSRC)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (ctl_s1),
		.w_in    (w_s1),
		.x_in    (x_s1),
		.ctl_out (ctl_done),
		.act_out (act_done)
	);

	assign diff = 18'(tgt_q) - 18'(act_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (ctl_done.vld && ctl_done.outl) begin
			ovld_q <= 1'b1;
		end else if (m_tready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_done.vld && ctl_done.outl) begin
			on_q    <= ctl_done.idx[2:0];
			oact_q  <= act_done;
			olast_q <= ctl_done.lastn;
			oerr_q  <= (diff < -18'sd32768) ? -16'sh8000 : diff[15:0];
		end
	end

	assign m_tvalid = ovld_q;
	assign m_tdata  = {oerr_q, oact_q, on_q};
	assign m_tlast  = olast_q;

endmodule

// File: sv/mlp_fwd_mac.sv
module mlp_fwd_mac
	import mlp_pkg::*;
#(
	parameter int WSRC = MAX_INPUTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mac_ctl_t           ctl_in,
	input  logic signed [15:0] w_in,
	input  logic signed [15:0] x_in,
	output mac_ctl_t           ctl_out,
	output logic [12:0]        act_out
);

	localparam int ACC_W = 32 + $clog2(WSRC + 1) + 1;
	localparam sig_tbl_t SIG_TBL = build_sig_tbl();
	localparam logic signed [ACC_W-1:0] SMAX = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SMIN = -ACC_W'(32768);

	mac_ctl_t                  ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic signed [31:0]        prod_s2;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [15:0]        sum_s4;
	logic [12:0]               act_s5;
	logic signed [ACC_W-1:0]   sh;
	logic [TBL_AW-1:0]         idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else begin
			ctl_s2 <= ctl_in;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= '{vld: ctl_s3.vld & ctl_s3.last, first: ctl_s3.first,
				last: ctl_s3.last, outl: ctl_s3.outl, lastn: ctl_s3.lastn,
				bank: ctl_s3.bank, idx: ctl_s3.idx};
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= w_in * x_in;
		if (ctl_s2.vld) begin
			if (ctl_s2.first) begin
				acc_q <= ACC_W'(prod_s2);
			end else begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
		sum_s4 <= (sh > SMAX) ? 16'sh7fff : (sh < SMIN) ? -16'sh8000 : sh[15:0];
		act_s5 <= SIG_TBL[idx];
	end

	assign sh  = acc_q >>> 12;
	assign idx = {~sum_s4[15], sum_s4[14 -: (TBL_AW - 1)]};

	assign ctl_out = ctl_s5;
	assign act_out = act_s5;

endmodule

// File: sim/mlp_checker.sv
module mlp_checker
	import mlp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [4:0]  cfg_data,
	output int          fail_count,
	output int          pending,
	output int          checked
);

	localparam int NI = MAX_INPUTS_DEF;
	localparam int NH = MAX_HIDDEN_DEF;
	localparam int NL = MAX_LAYERS_DEF;
	localparam int NO = MAX_OUTPUTS_DEF;
	localparam int SRC_SPAN = (NI > NH) ? NI : NH;
	localparam int WT_DEPTH = (NL * NH + NO) * SRC_SPAN;

	typedef struct {
		logic [2:0]         neuron;
		logic [12:0]        act;
		logic signed [15:0] err;
		logic               last;
	} out_beat_t;

	logic signed [15:0] weights [WT_DEPTH];
	logic signed [15:0] features [NI];
	logic [12:0]        sig_lut [TBL_DEPTH];
	logic [4:0]         n_in, n_hid;
	logic [2:0]         n_lay;
	logic [3:0]         n_out;
	out_beat_t          outbox [$];

	function automatic longint unsigned exp_q30(longint unsigned f);
		longint unsigned pos, neg, term;
		pos  = 64'd1 << 30;
		neg  = 0;
		term = 64'd1 << 30;
		for (int k = 1; k <= 24; k++) begin
			term = (term * f) / (64'd4096 * k);
			if (k[0]) neg += term;
			else pos += term;
		end
		return pos - neg;
	endfunction

	initial begin
		longint unsigned e_one, mag, e, den, val;
		longint          center;
		e_one = exp_q30(4096);
		for (int i = 0; i < TBL_DEPTH; i++) begin
			center = ((2 * longint'(i) + 1) * 65536) / (2 * TBL_DEPTH) - 32768;
			mag = (center < 0) ? -center : center;
			e = exp_q30(mag & 4095);
			for (longint unsigned u = 0; u < (mag >> 12); u++)
				e = (e * e_one) >> 30;
			den = (64'd1 << 30) + e;
			val = ((64'd4096 << 30) + den / 2) / den;
			sig_lut[i] = (center < 0) ? 13'(4096 - val) : 13'(val);
		end
	end

	function automatic int clampi(int v, int hi);
		return (v < 1) ? 1 : (v > hi) ? hi : v;
	endfunction

	function automatic logic [12:0] squash(longint acc);
		longint q;
		int     idx;
		q = acc >>> 12;
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		idx = int'(((q + 32768) * TBL_DEPTH) >> 16);
		if (idx >= TBL_DEPTH) idx = TBL_DEPTH - 1;
		return sig_lut[idx];
	endfunction

	task automatic forward_pass(logic signed [15:0] target);
		int        ni, nh, nl, no, nsrc;
		longint    acc, diff;
		int        prev_act [NH];
		int        cur_act [NH];
		out_beat_t b;
		ni = clampi(n_in, NI);
		nh = clampi(n_hid, NH);
		nl = clampi(n_lay, NL);
		no = clampi(n_out, (NO < RESULT_LIMIT) ? NO : RESULT_LIMIT);
		for (int l = 0; l < nl; l++) begin
			nsrc = (l == 0) ? ni : nh;
			for (int n = 0; n < nh; n++) begin
				acc = 0;
				for (int s = 0; s < nsrc; s++)
					acc += longint'(weights[(l * NH + n) * SRC_SPAN + s]) *
						((l == 0) ? longint'(features[s]) : longint'(prev_act[s]));
				cur_act[n] = squash(acc);
			end
			prev_act = cur_act;
		end
		for (int o = 0; o < no; o++) begin
			acc = 0;
			for (int s = 0; s < nh; s++)
				acc += longint'(weights[(NL * NH + o) * SRC_SPAN + s]) * prev_act[s];
			b.neuron = 3'(o);
			b.act    = squash(acc);
			diff     = longint'(target) - b.act;
			if (diff > 32767) diff = 32767;
			if (diff < -32768) diff = -32768;
			b.err  = 16'(diff);
			b.last = (o + 1 == no);
			outbox.push_back(b);
		end
	endtask

	task automatic report(string what, longint got, longint want);
		$display("mismatch on %s: got %0d, expected %0d", what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		checked    = 0;
	end

	assign pending = outbox.size();

	always @(posedge clk or negedge arst_n) begin
		logic [2:0]         lsel;
		logic [3:0]         nsel, ssel;
		logic signed [15:0] val;
		out_beat_t          want;
		if (!arst_n) begin
			foreach (weights[i]) weights[i] = '0;
			foreach (features[i]) features[i] = '0;
			n_in  = 2;
			n_hid = 2;
			n_lay = 2;
			n_out = 1;
			outbox.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_addr))
					CFG_INPUTS:  n_in  = cfg_data;
					CFG_HIDDEN:  n_hid = cfg_data;
					CFG_LAYERS:  n_lay = cfg_data[2:0];
					CFG_OUTPUTS: n_out = cfg_data[3:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				checked++;
				if (outbox.size() == 0) begin
					report("unexpected result beat", m_tdata, 0);
				end else begin
					want = outbox.pop_front();
					if (m_tdata[2:0] != want.neuron)
						report("out_neuron", m_tdata[2:0], want.neuron);
					if (m_tdata[15:3] != want.act)
						report("out_activation", m_tdata[15:3], want.act);
					if ($signed(m_tdata[31:16]) != want.err)
						report("out_error", $signed(m_tdata[31:16]), want.err);
					if (m_tlast != want.last)
						report("out_last", m_tlast, want.last);
				end
			end
			if (s_tvalid && s_tready) begin
				lsel = s_tdata[2:0];
				nsel = s_tdata[6:3];
				ssel = s_tdata[10:7];
				val  = s_tdata[26:11];
				case (req_t'(s_tuser))
					REQ_WEIGHT: begin
						if (lsel < NL && nsel < NH && ssel < ((lsel == 0) ? NI : NH))
							weights[(lsel * NH + nsel) * SRC_SPAN + ssel] = val;
						else if (lsel == OUT_LAYER_SEL && nsel < NO && ssel < NH)
							weights[(NL * NH + nsel) * SRC_SPAN + ssel] = val;
					end
					REQ_FEATURE: if (ssel < NI) features[ssel] = val;
					REQ_TARGET:  forward_pass(val);
					default: ;
				endcase
			end
		end
	end

endmodule

// File: sim/testbench.sv
module testbench;
	import mlp_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_addr = '0;
	logic [4:0]  cfg_data = '0;
	int          errors, pending, results;
	int          beats, runs, settings, quiet_cnt;
	bit          calm;
	int          go_run, m_run, m_hold;
	int          ni, nh, nl, no;

	mlp_forward_inference_core i_dut (.*);

	mlp_checker i_chk (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .m_tlast, .cfg_we, .cfg_addr, .cfg_data,
		.fail_count(errors), .pending(pending), .checked(results)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (calm) begin
			m_tready <= 1'b1;
		end else if (m_hold > 0) begin
			m_hold--;
			m_tready <= 1'b0;
		end else if (m_run > 0) begin
			m_run--;
			m_tready <= 1'b1;
		end else if ($urandom_range(0, 2) == 0) begin
			m_hold = $urandom_range(1, 16) - 1;
			m_tready <= 1'b0;
		end else begin
			m_run = $urandom_range(1, 40);
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cnt = 0;
		else if (++quiet_cnt >= STALL_LIMIT) begin
			$display("timeout: no beat for %0d cycles", STALL_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send(req_t req, logic [2:0] lsel, logic [3:0] nsel, logic [3:0] ssel,
			logic [15:0] value);
		int gap;
		@(negedge clk);
		gap = 0;
		if (!calm) begin
			if (go_run > 0) go_run--;
			else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 16);
			else go_run = $urandom_range(1, 30);
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {5'b0, value, ssel, nsel, lsel};
		do @(posedge clk); while (!s_tready);
		beats++;
		if (req == REQ_TARGET) runs++;
	endtask

	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	task automatic set_reg(cfg_idx_t idx, logic [4:0] value);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(int a, int b, int c, int d);
		set_reg(CFG_INPUTS, 5'(a));
		set_reg(CFG_HIDDEN, 5'(b));
		set_reg(CFG_LAYERS, 5'(c));
		set_reg(CFG_OUTPUTS, 5'(d));
		ni = (a[4:0] == 0) ? 1 : (a[4:0] > 16) ? 16 : a[4:0];
		nh = (b[4:0] == 0) ? 1 : (b[4:0] > 16) ? 16 : b[4:0];
		nl = (c[2:0] == 0) ? 1 : (c[2:0] > 4) ? 4 : c[2:0];
		no = (d[3:0] == 0) ? 1 : (d[3:0] > 8) ? 8 : d[3:0];
		settings++;
	endtask

	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 16'h7fff;
			1: return 16'h8000;
			2, 3: return 16'($urandom);
			default: return 16'($signed($urandom_range(0, 16383)) - 8192);
		endcase
	endfunction

	task automatic random_items(int count);
		int         r;
		logic [2:0] lsel;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 7) begin
				send(REQ_NONE, 3'($urandom), 4'($urandom), 4'($urandom), 16'($urandom));
			end else if (r < 25) begin
				send(REQ_TARGET, 3'($urandom), 4'($urandom), 4'($urandom), pick_value());
			end else if (r < 42) begin
				send(REQ_FEATURE, 3'($urandom), 4'($urandom),
					($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, ni - 1)),
					pick_value());
			end else if ($urandom_range(0, 4) == 0) begin
				send(REQ_WEIGHT, 3'($urandom), 4'($urandom), 4'($urandom), pick_value());
			end else begin
				lsel = ($urandom_range(0, 2) == 0) ? 3'(OUT_LAYER_SEL) : 3'($urandom_range(0, nl - 1));
				send(REQ_WEIGHT, lsel,
					4'($urandom_range(0, ((lsel == OUT_LAYER_SEL) ? no : nh) - 1)),
					4'($urandom_range(0, ((lsel == 0) ? ni : nh) - 1)), pick_value());
			end
		end
	endtask

	initial begin
		ni = 2; nh = 2; nl = 2; no = 1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (!s_tready) @(negedge clk);

		send(REQ_FEATURE, 3'd0, 4'd0, 4'd0, 16'h7fff);
		send(REQ_FEATURE, 3'd0, 4'd0, 4'd1, 16'h8000);
		send(REQ_TARGET, 3'd0, 4'd0, 4'd0, 16'd0);
		send(REQ_WEIGHT, 3'd0, 4'd0, 4'd0, 16'h7fff);
		send(REQ_WEIGHT, 3'd0, 4'd0, 4'd1, 16'h8000);
		send(REQ_WEIGHT, 3'd0, 4'd1, 4'd0, 16'd4096);
		send(REQ_WEIGHT, 3'd1, 4'd0, 4'd0, 16'd8192);
		send(REQ_WEIGHT, 3'd1, 4'd1, 4'd1, -16'sd8192);
		send(REQ_WEIGHT, 3'd4, 4'd0, 4'd0, 16'd16384);
		send(REQ_WEIGHT, 3'd4, 4'd0, 4'd1, -16'sd4096);
		send(REQ_TARGET, 3'd0, 4'd0, 4'd0, 16'h7fff);
		send(REQ_TARGET, 3'd0, 4'd0, 4'd0, 16'h8000);
		send(REQ_WEIGHT, 3'd4, 4'd7, 4'd15, 16'd1234);
		send(REQ_WEIGHT, 3'd3, 4'd15, 4'd15, 16'hffff);
		send(REQ_WEIGHT, 3'd7, 4'd15, 4'd15, 16'h7fff);
		send(REQ_WEIGHT, 3'd5, 4'd0, 4'd0, 16'h7fff);
		send(REQ_WEIGHT, 3'd4, 4'd8, 4'd0, 16'h7fff);
		send(REQ_WEIGHT, 3'd4, 4'd15, 4'd1, 16'h8000);
		send(REQ_FEATURE, 3'd7, 4'd15, 4'd15, 16'd1);
		send(REQ_NONE, 3'd7, 4'd15, 4'd15, 16'hffff);
		send(REQ_TARGET, 3'd7, 4'd15, 4'd15, 16'd4096);
		settle();

		configure(1, 1, 1, 1);
		random_items(50);
		settle();
		configure(16, 16, 4, 8);
		random_items(30);
		settle();
		configure(0, 0, 0, 0);
		random_items(50);
		settle();
		configure(31, 31, 7, 15);
		random_items(25);
		settle();
		for (int p = 0; p < 4; p++) begin
			configure($urandom_range(1, 5), $urandom_range(1, 5), $urandom_range(1, 3),
				$urandom_range(1, 8));
			random_items(60);
			settle();
		end
		calm = 1'b1;
		configure(3, 4, 2, 3);
		random_items(60);
		settle();
		repeat (50) @(negedge clk);

		$display("sent %0d input beats, %0d inference runs, over %0d register settings",
			beats, runs, settings);
		$display("checked %0d result beats", results);
		if (errors == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// File: sim.f
sv/mlp_pkg.sv
sv/mlp_fwd_mac.sv
sv/mlp_forward_inference_core.sv
sim/mlp_checker.sv
sim/testbench.sv
